// ----- rtl/mi3_pkg.sv -----
// Shared constants, types and tables for the 3x3 fixed-point matrix inverse.
package mi3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int CMAG_W    = 2 * ELEM_W;           // cofactor magnitude
    localparam int TERM_W    = CMAG_W + ELEM_W;      // det term magnitude
    localparam int DET_W     = TERM_W + 2;           // signed determinant
    localparam int DMAG_W    = DET_W - 1;            // determinant magnitude
    localparam int NUM_W     = CMAG_W + 2 * FRAC_BITS;
    localparam int QSTEPS    = ELEM_W;               // quotient bits, one per stage
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef logic [3:0] t_idx;

    // adj[i] = a[p0]*a[p1] - a[q0]*a[q1], row-major element indexes
    localparam t_idx IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic [8:0][CMAG_W-1:0] cmag;
        logic [8:0]             cneg;
        logic [DMAG_W-1:0]      dmag;
        logic                   dneg;
        logic                   zero;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [8:0][ELEM_W-1:0] r;
        logic                   singular;
    } t_result;

endpackage

// ----- rtl/matrix_inverse_3x3.sv -----
// Pipeline: 7 front stages, queue write, 33 divider stages, output register.
// Throughput: one matrix per cycle unless the queue fills or output stalls;
// the 32-stage quotient pipeline sets depth.
// Reset (i_rst_n low, synchronous) empties pipelines and queue; data regs keep
// their contents, valid flags clear.
module matrix_inverse_3x3 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_a00,
    input  logic [31:0] i_a01,
    input  logic [31:0] i_a02,
    input  logic [31:0] i_a10,
    input  logic [31:0] i_a11,
    input  logic [31:0] i_a12,
    input  logic [31:0] i_a20,
    input  logic [31:0] i_a21,
    input  logic [31:0] i_a22,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_r00,
    output logic [31:0] o_r01,
    output logic [31:0] o_r02,
    output logic [31:0] o_r10,
    output logic [31:0] o_r11,
    output logic [31:0] o_r12,
    output logic [31:0] o_r20,
    output logic [31:0] o_r21,
    output logic [31:0] o_r22,
    output logic        o_singular
);
    import mi3_pkg::*;

    logic [8:0][ELEM_W-1:0] a;
    logic                   push, pop;
    t_item                  f_item, q_item;
    t_qstat                 qstat;
    t_result                res;

    // element 0 is a00, row-major
    assign a = {i_a22, i_a21, i_a20, i_a12, i_a11, i_a10, i_a02, i_a01, i_a00};

    // front: cofactors and determinant, stalls only on a full queue
    mi3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_a     (a),
        .i_qstat (qstat),
        .o_push  (push),
        .o_item  (f_item)
    );

    // request queue decouples front stalls from output back-pressure
    mi3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_qstat (qstat)
    );

    // back: pipelined division by |det| and saturation to Q16.16
    mi3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (q_item),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res)
    );

    assign o_r00      = res.r[0];
    assign o_r01      = res.r[1];
    assign o_r02      = res.r[2];
    assign o_r10      = res.r[3];
    assign o_r11      = res.r[4];
    assign o_r12      = res.r[5];
    assign o_r20      = res.r[6];
    assign o_r21      = res.r[7];
    assign o_r22      = res.r[8];
    assign o_singular = res.singular;

endmodule

// ----- rtl/mi3_front.sv -----
// Front pipeline: cofactors, determinant and its sign and magnitude.
module mi3_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [8:0][mi3_pkg::ELEM_W-1:0]        i_a,
    input  mi3_pkg::t_qstat                        i_qstat,
    output logic                                   o_push,
    output mi3_pkg::t_item                         o_item
);
    import mi3_pkg::*;

    logic                     en;
    logic                     r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    logic signed [CMAG_W-1:0] r1_p [9];
    logic signed [CMAG_W-1:0] r1_q [9];
    logic signed [ELEM_W-1:0] r1_e [3];
    logic [CMAG_W-1:0]        r2_cmag [9];
    logic [8:0]               r2_cneg;
    logic [ELEM_W-1:0]        r2_emag [3];
    logic [2:0]               r2_eneg;
    logic [CMAG_W-1:0]        r3_cmag [9];
    logic [8:0]               r3_cneg;
    logic [CMAG_W-1:0]        r3_plo [3];
    logic [CMAG_W-1:0]        r3_phi [3];
    logic [2:0]               r3_tneg;
    logic [CMAG_W-1:0]        r4_cmag [9];
    logic [8:0]               r4_cneg;
    logic [TERM_W-1:0]        r4_tmag [3];
    logic [2:0]               r4_tneg;
    logic [CMAG_W-1:0]        r5_cmag [9];
    logic [8:0]               r5_cneg;
    logic signed [DET_W-1:0]  r5_s01, r5_t2;
    logic [CMAG_W-1:0]        r6_cmag [9];
    logic [8:0]               r6_cneg;
    logic signed [DET_W-1:0]  r6_det;
    t_item                    r7_item;

    function automatic logic signed [DET_W-1:0] f_sign(input logic [TERM_W-1:0] m,
                                                      input logic neg);
        logic signed [DET_W-1:0] v;
        v = $signed({2'b00, m});
        return neg ? -v : v;
    endfunction

    // whole pipe holds while the last stage waits on a full queue
    assign en      = !(r7_v && i_qstat.full);
    assign o_ready = en;
    assign o_push  = r7_v && !i_qstat.full;
    assign o_item  = r7_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid; r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v;
            r5_v <= r4_v; r6_v <= r5_v; r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                r1_p[i] <= CMAG_W'($signed(i_a[IDX[i][0]])) * CMAG_W'($signed(i_a[IDX[i][1]]));
                r1_q[i] <= CMAG_W'($signed(i_a[IDX[i][2]])) * CMAG_W'($signed(i_a[IDX[i][3]]));
                if (r1_p[i] >= r1_q[i]) begin
                    r2_cmag[i] <= r1_p[i] - r1_q[i];
                    r2_cneg[i] <= 1'b0;
                end else begin
                    r2_cmag[i] <= r1_q[i] - r1_p[i];
                    r2_cneg[i] <= 1'b1;
                end
                r3_cmag[i] <= r2_cmag[i];
                r4_cmag[i] <= r3_cmag[i];
                r5_cmag[i] <= r4_cmag[i];
                r6_cmag[i] <= r5_cmag[i];
                r7_item.cmag[i] <= r6_cmag[i];
            end
            r3_cneg <= r2_cneg;
            r4_cneg <= r3_cneg;
            r5_cneg <= r4_cneg;
            r6_cneg <= r5_cneg;
            r7_item.cneg <= r6_cneg;
            for (int k = 0; k < 3; k++) begin
                r1_e[k]    <= $signed(i_a[k]);
                r2_eneg[k] <= r1_e[k][ELEM_W-1];
                r2_emag[k] <= r1_e[k][ELEM_W-1] ? ELEM_W'(-r1_e[k]) : r1_e[k];
                // 64x32 split into two 32x32 partial products
                r3_plo[k]  <= {{ELEM_W{1'b0}}, r2_cmag[3*k][ELEM_W-1:0]}
                              * {{ELEM_W{1'b0}}, r2_emag[k]};
                r3_phi[k]  <= {{ELEM_W{1'b0}}, r2_cmag[3*k][CMAG_W-1:ELEM_W]}
                              * {{ELEM_W{1'b0}}, r2_emag[k]};
                r3_tneg[k] <= r2_eneg[k] ^ r2_cneg[3*k];
                r4_tmag[k] <= {r3_phi[k], {ELEM_W{1'b0}}} + {{ELEM_W{1'b0}}, r3_plo[k]};
            end
            r4_tneg <= r3_tneg;
            r5_s01  <= f_sign(r4_tmag[0], r4_tneg[0]) + f_sign(r4_tmag[1], r4_tneg[1]);
            r5_t2   <= f_sign(r4_tmag[2], r4_tneg[2]);
            r6_det  <= r5_s01 + r5_t2;
            r7_item.zero <= (r6_det == '0);
            r7_item.dneg <= r6_det[DET_W-1];
            r7_item.dmag <= r6_det[DET_W-1] ? DMAG_W'(-r6_det) : DMAG_W'(r6_det);
        end
    end

endmodule

// ----- rtl/mi3_queue.sv -----
// Short request queue between the front and back pipelines.
module mi3_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mi3_pkg::t_item  i_item,
    input  logic            i_pop,
    output mi3_pkg::t_item  o_item,
    output mi3_pkg::t_qstat o_qstat
);
    import mi3_pkg::*;

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_qstat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_item        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ----- rtl/mi3_back.sv -----
// Back pipeline: one quotient bit per stage for nine lanes, then saturation.
module mi3_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mi3_pkg::t_item   i_item,
    input  mi3_pkg::t_qstat  i_qstat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output mi3_pkg::t_result o_res
);
    import mi3_pkg::*;

    logic                en;
    logic                r_v    [QSTEPS+1];
    logic                r_zero [QSTEPS+1];
    logic [8:0]          r_neg  [QSTEPS+1];
    logic [8:0]          r_sat  [QSTEPS+1];
    logic [DMAG_W-1:0]   r_dmag [QSTEPS+1];
    logic [DMAG_W-1:0]   r_rem  [QSTEPS+1][9];
    logic [ELEM_W-1:0]   r_lq   [QSTEPS+1][9];
    logic [DMAG_W-1:0]   n_rem  [QSTEPS+1][9];
    logic [ELEM_W-1:0]   n_lq   [QSTEPS+1][9];
    logic [8:0]          n_sat;
    logic [NUM_W-1:0]    num;
    logic [DMAG_W:0]     t;
    logic                ge;
    logic [ELEM_W-1:0]   q;
    logic                r_ov;
    t_result             r_res, n_res;

    assign en      = !r_ov || i_ready;
    assign o_pop   = en && !i_qstat.empty;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_comb begin
        num   = '0;
        t     = '0;
        ge    = 1'b0;
        q     = '0;
        n_sat = '0;
        // stage 0: split numerator, flag quotients of 2^32 or more
        for (int j = 0; j < 9; j++) begin
            num         = {i_item.cmag[j], {(2*FRAC_BITS){1'b0}}};
            n_sat[j]    = DMAG_W'(num[NUM_W-1:ELEM_W]) >= i_item.dmag;
            n_rem[0][j] = DMAG_W'(num[NUM_W-1:ELEM_W]);
            n_lq[0][j]  = num[ELEM_W-1:0];
        end
        // restoring steps: numerator bits shift out of lq, quotient bits in
        for (int k = 1; k <= QSTEPS; k++) begin
            for (int j = 0; j < 9; j++) begin
                t  = {r_rem[k-1][j], r_lq[k-1][j][ELEM_W-1]};
                ge = t >= {1'b0, r_dmag[k-1]};
                n_rem[k][j] = ge ? DMAG_W'(t - {1'b0, r_dmag[k-1]}) : DMAG_W'(t);
                n_lq[k][j]  = {r_lq[k-1][j][ELEM_W-2:0], ge};
            end
        end
        n_res.singular = r_zero[QSTEPS];
        for (int j = 0; j < 9; j++) begin
            q = r_lq[QSTEPS][j];
            if (r_zero[QSTEPS])
                n_res.r[j] = '0;
            else if (r_sat[QSTEPS][j])
                n_res.r[j] = r_neg[QSTEPS][j] ? SAT_MIN : SAT_MAX;
            else if (r_neg[QSTEPS][j])
                n_res.r[j] = (q > SAT_MIN) ? SAT_MIN : -q;
            else
                n_res.r[j] = q[ELEM_W-1] ? SAT_MAX : q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QSTEPS; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_qstat.empty;
            for (int k = 1; k <= QSTEPS; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[QSTEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero[0] <= i_item.zero;
            r_neg[0]  <= i_item.cneg ^ {9{i_item.dneg}};
            r_sat[0]  <= n_sat;
            r_dmag[0] <= i_item.dmag;
            for (int k = 1; k <= QSTEPS; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_sat[k]  <= r_sat[k-1];
                r_dmag[k] <= r_dmag[k-1];
            end
            for (int k = 0; k <= QSTEPS; k++) begin
                for (int j = 0; j < 9; j++) begin
                    r_rem[k][j] <= n_rem[k][j];
                    r_lq[k][j]  <= n_lq[k][j];
                end
            end
            r_res <= n_res;
        end
    end

endmodule

// ----- rtl/mi3_checker.sv -----
// Port-level checks for the matrix inverse and their binding.
module mi3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_r00,
    input logic [31:0] o_r01,
    input logic [31:0] o_r02,
    input logic [31:0] o_r10,
    input logic [31:0] o_r11,
    input logic [31:0] o_r12,
    input logic [31:0] o_r20,
    input logic [31:0] o_r21,
    input logic [31:0] o_r22,
    input logic        o_singular
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_r00) && $stable(o_r11)
            && $stable(o_r22) && $stable(o_singular))
        else $error("stalled result changed");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> (o_r00 == 0) && (o_r01 == 0) && (o_r02 == 0)
            && (o_r10 == 0) && (o_r11 == 0) && (o_r12 == 0) && (o_r20 == 0)
            && (o_r21 == 0) && (o_r22 == 0))
        else $error("singular result not all zero");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind matrix_inverse_3x3 mi3_checker u_chk (.*);
